// ----- src/tshd_pkg.sv -----
// Shared types, constants and decode functions for the thermostat readout block.
`default_nettype none
package tshd_pkg;

  localparam int SAMPLE_BITS_DEF = 10;
  localparam int VAL_W           = 16;
  localparam int SEG_W           = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int FRAC_SHIFT      = 10;
  localparam int FIFO_DEPTH      = 2;

  localparam logic [VAL_W-1:0] HIGH_THR_RST = 16'd3800;
  localparam logic [VAL_W-1:0] LOW_THR_RST  = 16'd3600;
  localparam logic [VAL_W-1:0] SCALE_RST    = 16'd50000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HIGH_THR = 2'd0,
    CFG_LOW_THR  = 2'd1,
    CFG_SCALE    = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_t;

  // Scaled value word handed from the front end into the queue.
  typedef struct packed {
    logic             vld;
    logic [VAL_W-1:0] value;
  } word_push_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] units;
  } dec_pair_t;

  // Split 0..99 into two decimal digits; x*205>>11 is exact for x < 1029.
  function automatic dec_pair_t split_dec(input logic [6:0] x);
    logic [14:0] prod;
    dec_pair_t   res;
    prod      = 15'(x) * 15'd205;
    res.tens  = prod[14:11];
    res.units = 4'(x - 7'(7'(res.tens) * 7'd10));
    return res;
  endfunction

  // Segments g..a for one decimal digit.
  function automatic logic [6:0] seg_code(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- src/thermostat_hysteresis_seg_display.sv -----
// Top level: hysteresis thermostat with four-digit seven-segment readout.
// Each input word carries one converter sample. The sample is multiplied by
// scale_factor and shifted right by ten; the result saturates at 65535 and is
// reported as scaled_value. The heater drive switches off when the value is
// above high_threshold, on when it is below low_threshold (the off test wins
// when the thresholds are crossed), and holds otherwise; it starts off. The
// heartbeat bit inverts on every word, so the first result reports one. The
// value is shown as four decimal digits with leading zeros; a five-digit value
// shows its top four digits. Bit seven of each segment code is the decimal
// point, set on the second digit only; bits six to zero are segments g..a.
// Rate: one word per cycle sustained while out_ready stays high. A word passes
// from input accept through the product register in the front end, the
// two-entry queue and the back-end stages (divide-by-ten select, hundreds
// split, digit decode into the output register) to output valid. The output
// register holds a finished word while the front end keeps accepting until
// the queue and the product register are full. Configuration writes are
// always accepted; write them only while no word is in flight. Indexes beyond
// the register list are ignored.
`default_nettype none
module thermostat_hysteresis_seg_display #(
  parameter int SAMPLE_BITS = tshd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,

  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [SAMPLE_BITS-1:0]         in_adc_sample,

  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_heater_on,
  output logic                                out_alive_toggle,
  output logic [tshd_pkg::VAL_W-1:0]          out_scaled_value,
  output logic [tshd_pkg::SEG_W-1:0]          out_seg_digit0,
  output logic [tshd_pkg::SEG_W-1:0]          out_seg_digit1,
  output logic [tshd_pkg::SEG_W-1:0]          out_seg_digit2,
  output logic [tshd_pkg::SEG_W-1:0]          out_seg_digit3,

  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tshd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tshd_pkg::VAL_W-1:0]     cfg_data
);
  import tshd_pkg::*;

  logic [VAL_W-1:0] high_thr_r;
  logic [VAL_W-1:0] low_thr_r;
  logic [VAL_W-1:0] scale_r;

  word_push_t       push;
  fifo_st_t         fifo_st;
  logic [VAL_W-1:0] rd_value;
  logic             pop;

  // Configuration registers: always ready, one write per cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r <= HIGH_THR_RST;
      low_thr_r  <= LOW_THR_RST;
      scale_r    <= SCALE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HIGH_THR: high_thr_r <= cfg_data;
        CFG_LOW_THR:  low_thr_r  <= cfg_data;
        CFG_SCALE:    scale_r    <= cfg_data;
        default:      ;  // drop writes to unused indexes
      endcase
    end
  end

  // Front end: accept and scale the sample.
  tshd_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_adc_sample (in_adc_sample),
    .scale_factor  (scale_r),
    .fifo_st       (fifo_st),
    .push          (push)
  );

  // Queue: decouple front and back so each can stall on its own.
  tshd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .rd_value (rd_value),
    .st       (fifo_st)
  );

  // Back end: advance state, decode digits, present the result word.
  tshd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fifo_st          (fifo_st),
    .rd_value         (rd_value),
    .pop              (pop),
    .high_threshold   (high_thr_r),
    .low_threshold    (low_thr_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_heater_on    (out_heater_on),
    .out_alive_toggle (out_alive_toggle),
    .out_scaled_value (out_scaled_value),
    .out_seg_digit0   (out_seg_digit0),
    .out_seg_digit1   (out_seg_digit1),
    .out_seg_digit2   (out_seg_digit2),
    .out_seg_digit3   (out_seg_digit3)
  );

endmodule
`default_nettype wire

// ----- src/tshd_front.sv -----
// Front end: accept samples, multiply by the scale factor, saturate, push to the queue.
`default_nettype none
module tshd_front #(
  parameter int SAMPLE_BITS = tshd_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [SAMPLE_BITS-1:0]     in_adc_sample,
  input  wire logic [tshd_pkg::VAL_W-1:0] scale_factor,
  input  wire tshd_pkg::fifo_st_t         fifo_st,
  output tshd_pkg::word_push_t            push
);
  import tshd_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + VAL_W;

  logic              vld_r, vld_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_sh;
  logic              accept;

  // Take a new word whenever the product register is free or drains this cycle.
  assign in_ready = !vld_r || !fifo_st.full;
  assign accept   = in_valid && in_ready;

  assign prod_sh    = prod_r >> FRAC_SHIFT;
  assign push.vld   = vld_r && !fifo_st.full;
  assign push.value = (prod_sh > PROD_W'(16'hFFFF)) ? 16'hFFFF : prod_sh[VAL_W-1:0];

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (push.vld) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r <= PROD_W'(in_adc_sample) * PROD_W'(scale_factor);
    end
  end

endmodule
`default_nettype wire

// ----- src/tshd_fifo.sv -----
// Short queue of scaled values between front end and back end.
`default_nettype none
module tshd_fifo (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire tshd_pkg::word_push_t       push,
  input  wire logic                       pop,
  output logic [tshd_pkg::VAL_W-1:0]      rd_value,
  output tshd_pkg::fifo_st_t              st
);
  import tshd_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [VAL_W-1:0] mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign st.full  = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign st.empty = (cnt_r == '0);
  assign rd_value = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push.vld) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push.vld && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push.vld) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      mem_r[wr_ptr_r] <= push.value;
    end
  end

endmodule
`default_nettype wire

// ----- src/tshd_back.sv -----
// Back end: hysteresis, heartbeat and decimal segment decode, three stages deep.
`default_nettype none
module tshd_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire tshd_pkg::fifo_st_t         fifo_st,
  input  wire logic [tshd_pkg::VAL_W-1:0] rd_value,
  output logic                            pop,
  input  wire logic [tshd_pkg::VAL_W-1:0] high_threshold,
  input  wire logic [tshd_pkg::VAL_W-1:0] low_threshold,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_heater_on,
  output logic                            out_alive_toggle,
  output logic [tshd_pkg::VAL_W-1:0]      out_scaled_value,
  output logic [tshd_pkg::SEG_W-1:0]      out_seg_digit0,
  output logic [tshd_pkg::SEG_W-1:0]      out_seg_digit1,
  output logic [tshd_pkg::SEG_W-1:0]      out_seg_digit2,
  output logic [tshd_pkg::SEG_W-1:0]      out_seg_digit3
);
  import tshd_pkg::*;

  localparam int SHOWN_W = 14;

  logic               adv;
  logic               heater_r, heater_nxt;
  logic               beat_r;

  logic               s1_vld_r, s2_vld_r, out_vld_r;
  logic [VAL_W-1:0]   s1_value_r, s2_value_r;
  logic [SHOWN_W-1:0] s1_shown_r, s2_shown_r;
  logic               s1_heater_r, s2_heater_r;
  logic               s1_beat_r, s2_beat_r;
  logic [6:0]         s2_hi_r;

  logic [32:0]        q10_prod;
  logic [SHOWN_W-1:0] shown;
  logic [26:0]        hi_prod;
  logic [SHOWN_W-1:0] lo_full;
  dec_pair_t          hi_dig, lo_dig;

  // Move the whole chain forward unless the output word is stalled.
  assign adv = !out_vld_r || out_ready;
  assign pop = adv && !fifo_st.empty;

  // Stage one: five-digit values show value / 10 (x*52429>>19 exact on 16 bits).
  assign q10_prod = 33'(rd_value) * 33'd52429;
  assign shown    = (rd_value >= 16'd10000) ? q10_prod[19+SHOWN_W-1:19]
                                            : rd_value[SHOWN_W-1:0];

  always_comb begin
    heater_nxt = heater_r;
    if (rd_value > high_threshold) begin
      heater_nxt = 1'b0;
    end else if (rd_value < low_threshold) begin
      heater_nxt = 1'b1;
    end
  end

  // Stage two: hundreds part, x*5243>>19 exact below 43699.
  assign hi_prod = 27'(s1_shown_r) * 27'd5243;

  // Stage three: remainder below 100, then digit pairs.
  assign lo_full = s2_shown_r - SHOWN_W'(SHOWN_W'(s2_hi_r) * SHOWN_W'(100));
  assign hi_dig  = split_dec(s2_hi_r);
  assign lo_dig  = split_dec(lo_full[6:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heater_r  <= 1'b0;
      beat_r    <= 1'b0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= pop;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
      if (pop) begin
        heater_r <= heater_nxt;
        beat_r   <= !beat_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_value_r  <= rd_value;
      s1_shown_r  <= shown;
      s1_heater_r <= heater_nxt;
      s1_beat_r   <= !beat_r;

      s2_value_r  <= s1_value_r;
      s2_shown_r  <= s1_shown_r;
      s2_heater_r <= s1_heater_r;
      s2_beat_r   <= s1_beat_r;
      s2_hi_r     <= hi_prod[25:19];

      out_heater_on    <= s2_heater_r;
      out_alive_toggle <= s2_beat_r;
      out_scaled_value <= s2_value_r;
      out_seg_digit0   <= {1'b0, seg_code(hi_dig.tens)};
      out_seg_digit1   <= {1'b1, seg_code(hi_dig.units)};
      out_seg_digit2   <= {1'b0, seg_code(lo_dig.tens)};
      out_seg_digit3   <= {1'b0, seg_code(lo_dig.units)};
    end
  end

  assign out_valid = out_vld_r;

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the hysteresis thermostat with seven-segment readout.
`timescale 1ns / 100ps

module tb_top;
  import tshd_pkg::*;

  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  // Margin for the pipe from accept to result, plus a little slack.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 128;
  localparam int REPORT_CAP    = 200;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  // One expected readout word; seg[0] is the most significant shown digit.
  typedef struct packed {
    logic                 heater_on;
    logic                 alive_toggle;
    logic [VAL_W-1:0]     scaled_value;
    logic [3:0][SEG_W-1:0] seg;
  } readout_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PATTERN
  } ready_mode_t;

  // Keeps its own copy of the thermostat state and registers, predicts one
  // readout per accepted sample and matches results in order.
  class thermo_scoreboard;
    logic [VAL_W-1:0] high_thr;
    logic [VAL_W-1:0] low_thr;
    logic [VAL_W-1:0] scale;
    logic             heater;
    logic             beat;
    readout_t         readout_q[$];
    int               errors;
    logic [6:0]       seg_lut[10];

    function new();
      high_thr = HIGH_THR_RST;
      low_thr  = LOW_THR_RST;
      scale    = SCALE_RST;
      heater   = 1'b0;
      beat     = 1'b0;
      errors   = 0;
      seg_lut  = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};
    endfunction

    function void write_reg(cfg_idx_t idx, logic [VAL_W-1:0] data);
      case (idx)
        CFG_HIGH_THR: high_thr = data;
        CFG_LOW_THR:  low_thr  = data;
        CFG_SCALE:    scale    = data;
        default: ;
      endcase
    endfunction

    function void predict_readout(sample_t sample);
      longint unsigned prod;
      int unsigned     value;
      int unsigned     shown;
      logic [3:0]      dig[4];
      readout_t        r;
      prod  = (64'(sample) * 64'(scale)) >> FRAC_SHIFT;
      value = (prod > 64'd65535) ? 32'd65535 : 32'(prod);
      // Off test first: it wins when the thresholds are crossed.
      if (value > 32'(high_thr)) heater = 1'b0;
      else if (value < 32'(low_thr)) heater = 1'b1;
      beat  = ~beat;
      // Five-digit values show their top four digits.
      shown = (value >= 10000) ? value / 10 : value;
      for (int i = 3; i >= 0; i--) begin
        dig[i] = 4'(shown % 10);
        shown  = shown / 10;
      end
      r.heater_on    = heater;
      r.alive_toggle = beat;
      r.scaled_value = 16'(value);
      for (int i = 0; i < 4; i++) r.seg[i] = {1'b0, seg_lut[dig[i]]};
      r.seg[1][7] = 1'b1;
      readout_q.push_back(r);
    endfunction

    function void cmp_field(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(readout_t got);
      readout_t want;
      if (readout_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: unexpected result: expected none, actual scaled_value %0h",
                   $time, got.scaled_value);
        return;
      end
      want = readout_q.pop_front();
      cmp_field("heater_on", 16'(want.heater_on), 16'(got.heater_on));
      cmp_field("alive_toggle", 16'(want.alive_toggle), 16'(got.alive_toggle));
      cmp_field("scaled_value", want.scaled_value, got.scaled_value);
      for (int i = 0; i < 4; i++)
        cmp_field($sformatf("seg_digit%0d", i), 16'(want.seg[i]), 16'(got.seg[i]));
    endfunction

    function int pending();
      return readout_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  sample_t              in_adc_sample = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic                 out_heater_on;
  logic                 out_alive_toggle;
  logic [VAL_W-1:0]     out_scaled_value;
  logic [SEG_W-1:0]     out_seg_digit0;
  logic [SEG_W-1:0]     out_seg_digit1;
  logic [SEG_W-1:0]     out_seg_digit2;
  logic [SEG_W-1:0]     out_seg_digit3;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [VAL_W-1:0]     cfg_data      = '0;

  thermo_scoreboard sb = new();
  readout_t         observed;
  int               cycles = 0;
  int               burst_left = 0;
  ready_mode_t      ready_mode = RDY_ALWAYS;
  int               ready_left = 0;
  logic [2:0]       ready_phase = '0;

  thermostat_hysteresis_seg_display #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_adc_sample   (in_adc_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_heater_on   (out_heater_on),
    .out_alive_toggle(out_alive_toggle),
    .out_scaled_value(out_scaled_value),
    .out_seg_digit0  (out_seg_digit0),
    .out_seg_digit1  (out_seg_digit1),
    .out_seg_digit2  (out_seg_digit2),
    .out_seg_digit3  (out_seg_digit3),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: switch between stall styles after random stretches so stalls
  // land on every stage of the pipe, with full-rate stretches in between.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      ready_left <= $urandom_range(20, 300);
    end else begin
      ready_left <= ready_left - 1;
    end
    ready_phase <= ready_phase + 3'd1;
    case (ready_mode)
      RDY_ALWAYS:  out_ready <= 1'b1;
      RDY_COIN:    out_ready <= 1'($urandom_range(0, 1));
      RDY_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
      default:     out_ready <= (ready_phase < 3'd5);
    endcase
  end

  // Monitor: check the outgoing word first, then note the incoming sample, so
  // a word accepted on this edge can never match the sample taken on it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        observed.heater_on    = out_heater_on;
        observed.alive_toggle = out_alive_toggle;
        observed.scaled_value = out_scaled_value;
        observed.seg          = {out_seg_digit3, out_seg_digit2, out_seg_digit1, out_seg_digit0};
        sb.check_result(observed);
      end
      if (in_valid && in_ready) sb.predict_readout(in_adc_sample);
    end
  end

  // Present one sample and hold it until accepted. Call at a rising edge;
  // returns at the accepting edge with valid still high.
  task automatic send_sample(sample_t s);
    in_valid      <= 1'b1;
    in_adc_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Sender pacing: bursts of random length, then a random gap (possibly none).
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // Drop valid and hold until every predicted word has come out, then let
  // the pipe settle so a register write cannot hit a word in flight.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; update the predictor on the accepting edge.
  task automatic cfg_write(cfg_idx_t idx, logic [VAL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly aim at the thresholds so the heater keeps switching; the rest is
  // uniform noise and the two ends of the sample range.
  function automatic sample_t pick_sample();
    int unsigned roll;
    int unsigned target;
    int unsigned base;
    int          s;
    roll = $urandom_range(0, 99);
    if (roll < 5) return ($urandom_range(0, 1) != 0) ? '1 : '0;
    if (roll < 45 || sb.scale == 0) return SAMPLE_BITS'($urandom);
    target = ($urandom_range(0, 1) != 0) ? 32'(sb.high_thr) : 32'(sb.low_thr);
    base   = (target << FRAC_SHIFT) / 32'(sb.scale);
    s      = int'(base) + int'($urandom_range(0, 8)) - 4;
    if (s < 0) s = 0;
    if (s > (1 << SAMPLE_BITS) - 1) s = (1 << SAMPLE_BITS) - 1;
    return SAMPLE_BITS'(s);
  endfunction

  // Pick and write the settings of one random phase; the first phases pin
  // the thresholds and the scale at their extremes.
  task automatic setup_phase(int p);
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] sc;
    logic [VAL_W-1:0] tmp;
    lo = 16'($urandom_range(0, 40000));
    hi = 16'(32'(lo) + $urandom_range(0, 3000));
    sc = 16'($urandom_range(8000, 65535));
    case (p)
      0: begin
        hi = 16'hFFFF;
        lo = 16'hFFFF;
      end
      1: begin
        hi = 16'h0000;
        lo = 16'h0000;
      end
      2: sc = 16'hFFFF;
      default: begin
        // Cross the thresholds now and then.
        if ($urandom_range(0, 3) == 0) begin
          tmp = hi;
          hi  = lo;
          lo  = tmp;
        end
      end
    endcase
    cfg_write(CFG_SCALE, sc);
    cfg_write(CFG_HIGH_THR, hi);
    cfg_write(CFG_LOW_THR, lo);
    if (p % 3 == 0) cfg_write(CFG_UNUSED, 16'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero, full scale, short values with leading zeros,
    // five-digit values, and both heater edges around the band.
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'd1);
    send_sample(10'h155);
    send_sample(10'h2AA);
    send_sample(10'd73);
    send_sample(10'd76);
    send_sample(10'd78);
    send_sample(10'd76);
    send_sample(10'd74);
    send_sample(10'd73);
    send_sample(10'd20);
    send_sample(10'd205);
    send_sample(10'd204);
    drain();

    // A write past the register list must leave the thresholds alone.
    cfg_write(CFG_UNUSED, 16'hFFFF);
    send_sample(10'd73);
    send_sample(10'd78);
    drain();

    // Crossed thresholds: the off test must win.
    cfg_write(CFG_HIGH_THR, 16'd1000);
    cfg_write(CFG_LOW_THR, 16'd5000);
    send_sample(10'd41);
    send_sample(10'd10);
    send_sample(10'd100);
    drain();

    // Zero scale, then full scale with both thresholds at the top.
    cfg_write(CFG_SCALE, 16'd0);
    send_sample(10'd1023);
    send_sample(10'd512);
    drain();
    cfg_write(CFG_SCALE, 16'hFFFF);
    cfg_write(CFG_HIGH_THR, 16'hFFFF);
    cfg_write(CFG_LOW_THR, 16'hFFFF);
    send_sample(10'd1023);
    send_sample(10'd0);
    drain();

    // Unity scale: the value equals the sample.
    cfg_write(CFG_SCALE, 16'd1024);
    cfg_write(CFG_HIGH_THR, 16'd500);
    cfg_write(CFG_LOW_THR, 16'd400);
    send_sample(10'd600);
    send_sample(10'd450);
    send_sample(10'd399);
    drain();

    // Random phases; each one starts from an empty pipe.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      setup_phase(p);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(pick_sample());
        // Hold off mid-phase once until the pipe is empty.
        if (p == 4 && n == PHASE_ITEMS / 2) drain();
        else pace();
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- thermostat_hysteresis_seg_display.f -----
src/tshd_pkg.sv
src/tshd_front.sv
src/tshd_fifo.sv
src/tshd_back.sv
src/thermostat_hysteresis_seg_display.sv
tb/tb_top.sv
